// ----- design/tlcq_pkg.sv -----
`timescale 1ns / 1ps
package tlcq_pkg;

  typedef struct packed {
    logic [15:0] advance_samples;
    logic [30:0] query_position;
    logic [23:0] tolerance;
    logic [30:0] query_length;
    logic [2:0]  multiplier_select;
  } in_t;

  typedef struct packed {
    logic [30:0] position;
    logic [30:0] bar_number;
    logic        at_bar_start;
    logic [22:0] samples_to_next_bar;
    logic [31:0] next_beat_position;
    logic [31:0] next_bar_position;
    logic [31:0] nearest_beat_position;
    logic [31:0] nearest_bar_position;
    logic [33:0] position_beats;
    logic [2:0]  closest_multiplier;
    logic [29:0] multiplier_length;
  } out_t;

  // configuration register indexes
  localparam logic [1:0] REG_SAMPLE_RATE   = 2'd0;
  localparam logic [1:0] REG_TEMPO_BPM     = 2'd1;
  localparam logic [1:0] REG_BEATS_PER_BAR = 2'd2;
  localparam logic [1:0] REG_CYCLE_LENGTH  = 2'd3;

  localparam int CFG_W = 28;

  localparam logic [17:0] RATE_RESET = 18'd44100;
  localparam logic [8:0]  BPM_RESET  = 9'd120;
  localparam logic [4:0]  BPB_RESET  = 5'd4;
  localparam logic [8:0]  BPM_LOW    = 9'd40;
  localparam logic [8:0]  BPM_HIGH   = 9'd300;

  // multiplier codes
  localparam logic [2:0] MULT_QUARTER = 3'd0;
  localparam logic [2:0] MULT_HALF    = 3'd1;
  localparam logic [2:0] MULT_ONE     = 3'd2;
  localparam logic [2:0] MULT_TWO     = 3'd3;
  localparam logic [2:0] MULT_FOUR    = 3'd4;

  // bit-serial divider lanes
  localparam int DIV_W  = 48;
  localparam int DVS_W  = 32;
  localparam int CNT_W  = 6;
  localparam int LANES  = 6;

  localparam logic [CNT_W-1:0] STEPS_RATE  = 6'd24;
  localparam logic [CNT_W-1:0] STEPS_POS   = 6'd31;
  localparam logic [CNT_W-1:0] STEPS_ROUND = 6'd32;
  localparam logic [CNT_W-1:0] STEPS_BEATS = 6'd47;

endpackage

// ----- design/tlcq_div_lane.sv -----
`timescale 1ns / 1ps
module tlcq_div_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tlcq_pkg::CNT_W-1:0]  steps_i,
  input  logic [tlcq_pkg::DIV_W-1:0]  dividend_i,
  input  logic [tlcq_pkg::DVS_W-1:0]  divisor_i,
  output logic                        busy_o,
  output logic [tlcq_pkg::DIV_W-1:0]  quotient_o,
  output logic [tlcq_pkg::DVS_W-1:0]  remainder_o
);
  import tlcq_pkg::*;

  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] dq_q;
  logic [DVS_W-1:0] rem_q, dvs_q, rem_d;
  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] diff;
  logic             fits;

  // restoring step: dividend bits enter rem from the top of dq, quotient bits enter dq at the bottom
  always_comb begin
    shifted = {rem_q, dq_q[DIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
    fits    = !diff[DVS_W+1];
    rem_d   = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= steps_i;
      rem_q <= '0;
      dq_q  <= dividend_i;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
      rem_q <= rem_d;
      dq_q  <= {dq_q[DIV_W-2:0], fits};
    end
  end

  assign busy_o      = (cnt_q != '0);
  assign quotient_o  = dq_q;
  assign remainder_o = rem_q;

endmodule

// ----- design/tempo_loop_clock_quantizer.sv -----
`timescale 1ns / 1ps
// Looper master sample clock. Each request advances the position (saturating, then wrapping
// at cycle_length when set) and returns bar, beat and multiplier answers for the new position
// and the request's query fields. From acceptance to result, an item runs through two phases:
// a 31-step bit-serial phase for the position wrap and samples per beat, then a 47-step phase
// in which six bit-serial divider lanes run in parallel, the longest being the 16-bit fraction
// beat count. A new request is taken as soon as the block is back in idle, even while the
// previous result still waits in the output register. Configuration writes apply at once.
module tempo_loop_clock_quantizer #(
  parameter int POSITION_BITS = 31
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [tlcq_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  tlcq_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output tlcq_pkg::out_t             out_data_o
);
  import tlcq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD_A, ST_RUN_A, ST_LOAD_B, ST_RUN_B, ST_DONE
  } state_e;

  state_e state_q;

  logic [17:0] rate_q;
  logic [8:0]  bpm_q;
  logic [4:0]  bpb_q;
  logic [27:0] cycle_q;
  logic [POSITION_BITS-1:0] pos_q;
  in_t         req_q;
  logic [18:0] spb_q;
  logic [23:0] spbar_q;
  logic [2:0]  scan_k_q, best_q;
  logic [31:0] bestd_q;
  logic        out_valid_q;
  out_t        out_q;

  // lanes
  logic                          lane_start;
  logic [LANES-1:0]              lane_busy;
  logic [LANES-1:0][CNT_W-1:0]   lane_steps;
  logic [LANES-1:0][DIV_W-1:0]   lane_dvd, lane_quo;
  logic [LANES-1:0][DVS_W-1:0]   lane_dvs, lane_rem;

  logic [POSITION_BITS:0]   pos_sum;
  logic [POSITION_BITS-1:0] pos_sat, pos_wrap;
  logic [30:0] pos31;
  logic [23:0] rate60;
  logic [31:0] qh_beat, qh_bar;
  logic        phase_b;
  logic [18:0] spb_new;
  logic [8:0]  bpm_clamp;
  logic [29:0] scan_len;
  logic [31:0] scan_d;
  logic [23:0] to_bar;
  out_t        res;

  function automatic logic [29:0] scale_len(input logic [27:0] c, input logic [2:0] s);
    logic [29:0] r;
    unique case (s)
      MULT_QUARTER: r = 30'(c >> 2);
      MULT_HALF:    r = 30'(c >> 1);
      MULT_TWO:     r = {1'b0, c, 1'b0};
      MULT_FOUR:    r = {c, 2'b00};
      default:      r = {2'b00, c};
    endcase
    return r;
  endfunction

  always_comb begin
    pos_sum  = {1'b0, pos_q} + (POSITION_BITS+1)'(req_q.advance_samples);
    pos_sat  = pos_sum[POSITION_BITS] ? '1 : pos_sum[POSITION_BITS-1:0];
    pos31    = 31'(pos_q);
    rate60   = (24'(rate_q) << 6) - (24'(rate_q) << 2);
    qh_beat  = 32'(req_q.query_position) + 32'(spb_q >> 1);
    qh_bar   = 32'(req_q.query_position) + 32'(spbar_q >> 1);
    phase_b  = (state_q == ST_LOAD_B);
    spb_new  = lane_quo[0][18:0];
    pos_wrap = (cycle_q != '0 && 32'(pos_q) >= 32'(cycle_q))
               ? POSITION_BITS'(lane_rem[1]) : pos_q;
    bpm_clamp = cfg_data_i[8:0];
    if (bpm_clamp < BPM_LOW) bpm_clamp = BPM_LOW;
    if (bpm_clamp > BPM_HIGH) bpm_clamp = BPM_HIGH;
    scan_len = scale_len(cycle_q, scan_k_q);
    scan_d   = (32'(req_q.query_length) >= 32'(scan_len))
               ? 32'(req_q.query_length) - 32'(scan_len)
               : 32'(scan_len) - 32'(req_q.query_length);
  end

  always_comb begin
    lane_start = (state_q == ST_LOAD_A) || phase_b;
    lane_steps = '0;
    lane_dvd   = '0;
    lane_dvs   = '0;
    if (phase_b) begin
      lane_steps[0] = STEPS_POS;   lane_dvd[0] = {pos31, 17'b0};
      lane_dvs[0]   = 32'(spbar_q);
      lane_steps[1] = STEPS_POS;   lane_dvd[1] = {req_q.query_position, 17'b0};
      lane_dvs[1]   = 32'(spb_q);
      lane_steps[2] = STEPS_POS;   lane_dvd[2] = {req_q.query_position, 17'b0};
      lane_dvs[2]   = 32'(spbar_q);
      lane_steps[3] = STEPS_ROUND; lane_dvd[3] = {qh_beat, 16'b0};
      lane_dvs[3]   = 32'(spb_q);
      lane_steps[4] = STEPS_ROUND; lane_dvd[4] = {qh_bar, 16'b0};
      lane_dvs[4]   = 32'(spbar_q);
      lane_steps[5] = STEPS_BEATS; lane_dvd[5] = {pos31, 17'b0};
      lane_dvs[5]   = 32'(spb_q);
    end else begin
      lane_steps[0] = STEPS_RATE;  lane_dvd[0] = {rate60, 24'b0};
      lane_dvs[0]   = 32'(bpm_q);
      // wrap the advanced position, which lands in pos_q on this same edge
      lane_steps[1] = STEPS_POS;   lane_dvd[1] = {31'(pos_sat), 17'b0};
      lane_dvs[1]   = 32'(cycle_q);
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    tlcq_div_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (lane_start),
      .steps_i    (lane_steps[i]),
      .dividend_i (lane_dvd[i]),
      .divisor_i  (lane_dvs[i]),
      .busy_o     (lane_busy[i]),
      .quotient_o (lane_quo[i]),
      .remainder_o(lane_rem[i])
    );
  end

  // result assembly from the finished lanes
  always_comb begin
    res.position = pos31;
    to_bar = spbar_q - lane_rem[0][23:0];
    if (spbar_q != '0) begin
      res.bar_number          = lane_quo[0][30:0];
      res.at_bar_start        = (lane_rem[0] <= 32'(req_q.tolerance));
      res.samples_to_next_bar = to_bar[23] ? '1 : to_bar[22:0];
      res.next_bar_position   = 32'(req_q.query_position) - lane_rem[2] + 32'(spbar_q);
      res.nearest_bar_position = qh_bar - lane_rem[4];
    end else begin
      res.bar_number           = '0;
      res.at_bar_start         = 1'b0;
      res.samples_to_next_bar  = '0;
      res.next_bar_position    = 32'(req_q.query_position);
      res.nearest_bar_position = 32'(req_q.query_position);
    end
    if (spb_q != '0) begin
      res.next_beat_position    = 32'(req_q.query_position) - lane_rem[1] + 32'(spb_q);
      res.nearest_beat_position = qh_beat - lane_rem[3];
    end else begin
      res.next_beat_position    = 32'(req_q.query_position);
      res.nearest_beat_position = 32'(req_q.query_position);
    end
    if (cycle_q == '0 || spb_q == '0) res.position_beats = '0;
    else if (|lane_quo[5][DIV_W-1:34]) res.position_beats = '1;
    else res.position_beats = lane_quo[5][33:0];
    res.closest_multiplier = (cycle_q != '0 && req_q.query_length != '0) ? best_q : MULT_ONE;
    res.multiplier_length  = (cycle_q != '0)
                             ? scale_len(cycle_q, req_q.multiplier_select) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rate_q      <= RATE_RESET;
      bpm_q       <= BPM_RESET;
      bpb_q       <= BPB_RESET;
      cycle_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      scan_k_q    <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != ST_DONE) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SAMPLE_RATE:   rate_q <= cfg_data_i[17:0];
          REG_TEMPO_BPM:     bpm_q  <= bpm_clamp;
          REG_BEATS_PER_BAR: bpb_q  <= cfg_data_i[4:0];
          REG_CYCLE_LENGTH: begin
            cycle_q <= cfg_data_i;
            pos_q   <= '0;
          end
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            req_q   <= in_data_i;
            state_q <= ST_LOAD_A;
          end
        end
        ST_LOAD_A: begin
          pos_q   <= pos_sat;
          state_q <= ST_RUN_A;
        end
        ST_RUN_A: begin
          if (lane_busy == '0) begin
            pos_q   <= pos_wrap;
            spb_q   <= spb_new;
            spbar_q <= 24'(spb_new) * 24'(bpb_q);
            state_q <= ST_LOAD_B;
          end
        end
        ST_LOAD_B: begin
          scan_k_q <= MULT_QUARTER;
          state_q  <= ST_RUN_B;
        end
        ST_RUN_B: begin
          // nearest multiplier, one candidate per cycle
          if (scan_k_q <= MULT_FOUR) begin
            if (scan_k_q == MULT_QUARTER || scan_d < bestd_q) begin
              bestd_q <= scan_d;
              best_q  <= scan_k_q;
            end
            scan_k_q <= scan_k_q + 1'b1;
          end
          if (lane_busy == '0 && scan_k_q > MULT_FOUR) state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_wrapped_in_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD_B && cycle_q != '0) |-> (32'(pos_q) < 32'(cycle_q)))
    else $error("position not inside cycle after wrap");

  a_lanes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (lane_busy == '0))
    else $error("divider lane busy while idle");

  a_bar_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && spbar_q != '0) |-> (lane_rem[0] < 32'(spbar_q)))
    else $error("bar remainder out of range");

  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && (!out_valid_q || out_ready_i)) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("result not loaded on completion");

endmodule
